// ===== rtl/kas_pkg.sv =====
`default_nettype none

package kas_pkg;

  localparam int ANGLE_W      = 32;
  localparam int TRIG_FRAC    = 30;
  localparam int CORDIC_W     = 36;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
  localparam int ECC_W        = 16;
  localparam int MUL_A_W      = 18;
  localparam int PROD_W       = MUL_A_W + CORDIC_W;
  localparam int RESID_W      = 35;
  localparam int DEN_W        = 32;
  localparam int NUM_W        = 64;
  localparam int QUOT_BITS    = 42;
  localparam int STEP_W       = 41;
  localparam int ROOT_W       = 34;

  localparam int DEF_MAX_ITERATIONS  = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 29;

  localparam logic [STEP_W-1:0] STEP_LIMIT = 41'h100_0000_0000;

  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;
  localparam logic signed [CORDIC_W-1:0] PI_TRIG      = 36'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_TRIG = 36'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] GAIN_INV     = 36'sd652032874;

  localparam logic [ECC_W-1:0] ECC_RESET = 16'd0;
  localparam logic [ECC_W-1:0] TOL_RESET = 16'd537;

  typedef enum logic [0:0] {
    REG_ECC = 1'b0,
    REG_TOL = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [CORDIC_IDX_W-1:0] idx);
    case (idx)
      5'd0: atan_q30 = 36'sd843314857;
      5'd1: atan_q30 = 36'sd497837829;
      5'd2: atan_q30 = 36'sd263043837;
      5'd3: atan_q30 = 36'sd133525159;
      5'd4: atan_q30 = 36'sd67021687;
      5'd5: atan_q30 = 36'sd33543516;
      5'd6: atan_q30 = 36'sd16775851;
      5'd7: atan_q30 = 36'sd8388437;
      5'd8: atan_q30 = 36'sd4194283;
      5'd9: atan_q30 = 36'sd2097149;
      default: atan_q30 = CORDIC_W'(64'd1 << (TRIG_FRAC - int'(idx)));
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kepler_anomaly_solver.sv =====
`default_nettype none

// Solves E - e sin E = M by Newton steps from E = M and returns E, the true anomaly,
// a convergence flag and the step count. One word is taken at a time; mean_stall stays
// high until its result is loaded into the output register. Each Newton step runs a
// 30-step CORDIC sine/cosine, two shared multiplies and a 42-step bit-serial divide,
// and the closing pass runs a CORDIC sine/cosine, a 17-step square root and a 30-step
// CORDIC arctangent. A word runs k Newton steps, at most MAX_ITERATIONS. A stalled
// result word holds the sequencer in its last state. Registers: eccentricity at 0x0,
// step_tolerance at 0x4.
module kepler_anomaly_solver
  import kas_pkg::*;
#(
  parameter int MAX_ITERATIONS  = DEF_MAX_ITERATIONS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      mean_valid,
  output logic                      mean_stall,
  input  logic signed [ANGLE_W-1:0] mean_angle,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [ANGLE_W-1:0] eccentric_angle,
  output logic signed [ANGLE_W-1:0] true_angle,
  output logic                      converged,
  output logic [4:0]                steps_used
);

  localparam int SH = TRIG_FRAC - ANGLE_FRAC_BITS;
  localparam int NW = $clog2(MAX_ITERATIONS + 1);
  localparam logic [63:0] PI_ANGLE_U =
    (PI_Q62 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  localparam logic signed [ANGLE_W-1:0] PI_ANGLE = ANGLE_W'(PI_ANGLE_U);
  localparam logic signed [CORDIC_W-1:0] NU_HALF = CORDIC_W'(64'd1 << (SH - 1));
  localparam logic signed [RESID_W-1:0] ONE_Q30 = RESID_W'(64'd1 << TRIG_FRAC);
  localparam logic [ROOT_W-1:0] ROOT_TOP = ROOT_W'(64'd1 << 32);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_ROT_GO    = 16'h0002,
    S_ROT_WAIT  = 16'h0004,
    S_MUL_S     = 16'h0008,
    S_MUL_C     = 16'h0010,
    S_DEN       = 16'h0020,
    S_DIV_GO    = 16'h0040,
    S_DIV_WAIT  = 16'h0080,
    S_UPD       = 16'h0100,
    S_SQ        = 16'h0200,
    S_ROOT_INIT = 16'h0400,
    S_ROOT      = 16'h0800,
    S_MUL_Y     = 16'h1000,
    S_VEC_GO    = 16'h2000,
    S_VEC_WAIT  = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t state, state_next;

  logic [ECC_W-1:0]           ecc;
  logic [ECC_W-1:0]           tol;
  logic signed [ANGLE_W-1:0]  m, e, nu;
  logic [NW-1:0]              n;
  logic [NW-1:0]              n_inc;
  logic                       conv;
  logic                       final_pass;
  logic signed [CORDIC_W-1:0] s_val, c_val;
  logic signed [RESID_W-1:0]  f30;
  logic [DEN_W-1:0]           d30;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [CORDIC_W-1:0] mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [ROOT_W-1:0]          sq_v, sq_r, sq_bit, sq_t;

  logic                       accept;
  logic                       out_free;
  logic signed [ANGLE_W-1:0]  m_clamped;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [RESID_W-1:0]  diff_q30;
  logic signed [RESID_W-1:0]  den_full;
  logic signed [RESID_W-1:0]  f_mag;
  logic [NUM_W-1:0]           num;
  logic signed [STEP_W+1:0]   step_s;
  logic signed [STEP_W+1:0]   e_next_raw;
  logic signed [ANGLE_W-1:0]  e_next;
  logic signed [ANGLE_W:0]    delta_s;
  logic [ANGLE_W:0]           delta_abs;
  logic                       hit;
  logic signed [CORDIC_W-1:0] nu_full;

  cordic_ctrl_t               cctrl;
  logic signed [CORDIC_W-1:0] c_in_x, c_in_y, c_in_z;
  logic signed [CORDIC_W-1:0] c_out_x, c_out_y, c_out_z;
  logic                       c_done;
  logic                       d_done;
  logic [STEP_W-1:0]          quot;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ecc <= ECC_RESET;
      tol <= TOL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index_t'(paddr[2]))
        REG_ECC: ecc <= pwdata[ECC_W-1:0];
        REG_TOL: tol <= pwdata[ECC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_ECC: prdata = 32'(ecc);
      REG_TOL: prdata = 32'(tol);
      default: prdata = '0;
    endcase
  end

  // handshake
  assign mean_stall = rst || (state != S_IDLE);
  assign accept     = mean_valid && !mean_stall;
  assign out_free   = !result_valid || !result_stall;

  // shared units
  assign cctrl.start     = (state == S_ROT_GO) || (state == S_VEC_GO);
  assign cctrl.vectoring = (state == S_VEC_GO);
  assign c_in_z          = CORDIC_W'(e) <<< SH;
  assign c_in_y          = CORDIC_W'(prod_sh);
  assign c_in_x          = c_val - $signed(CORDIC_W'(ecc) << 14);

  kas_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cctrl),
    .in_x  (c_in_x),
    .in_y  (c_in_y),
    .in_z  (c_in_z),
    .done  (c_done),
    .out_x (c_out_x),
    .out_y (c_out_y),
    .out_z (c_out_z)
  );

  kas_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .num   (num),
    .den   (d30),
    .done  (d_done),
    .quot  (quot)
  );

  always_comb begin
    case (state)
      S_MUL_Y: begin
        mul_a = $signed({1'b0, sq_r[16:0]});
        mul_b = s_val;
      end
      S_MUL_C: begin
        mul_a = $signed({2'b00, ecc});
        mul_b = c_val;
      end
      S_SQ: begin
        mul_a = $signed({2'b00, ecc});
        mul_b = CORDIC_W'(ecc);
      end
      default: begin
        mul_a = $signed({2'b00, ecc});
        mul_b = s_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath terms
  always_comb begin
    if (mean_angle > PI_ANGLE) begin
      m_clamped = PI_ANGLE;
    end else if (mean_angle < -PI_ANGLE) begin
      m_clamped = -PI_ANGLE;
    end else begin
      m_clamped = mean_angle;
    end

    prod_sh  = prod >>> 16;
    diff_q30 = (RESID_W'(e) - RESID_W'(m)) <<< SH;
    den_full = ONE_Q30 - RESID_W'(prod_sh);
    f_mag    = (f30 < 0) ? -f30 : f30;
    num      = (NUM_W'($unsigned(f_mag)) << ANGLE_FRAC_BITS) + NUM_W'(d30 >> 1);

    step_s     = (f30 < 0) ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    e_next_raw = (STEP_W + 2)'(e) - step_s;
    if (e_next_raw > (STEP_W + 2)'(PI_ANGLE)) begin
      e_next = PI_ANGLE;
    end else if (e_next_raw < -(STEP_W + 2)'(PI_ANGLE)) begin
      e_next = -PI_ANGLE;
    end else begin
      e_next = ANGLE_W'(e_next_raw);
    end
    delta_s   = (ANGLE_W + 1)'(e_next) - (ANGLE_W + 1)'(e);
    delta_abs = (delta_s < 0) ? -delta_s : delta_s;
    hit       = delta_abs <= (ANGLE_W + 1)'(tol);
    n_inc     = n + 1'b1;

    sq_t    = sq_r + sq_bit;
    nu_full = (c_out_z + NU_HALF) >>> SH;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept) state_next = S_ROT_GO;
      S_ROT_GO:    state_next = S_ROT_WAIT;
      S_ROT_WAIT:  if (c_done) state_next = final_pass ? S_SQ : S_MUL_S;
      S_MUL_S:     state_next = S_MUL_C;
      S_MUL_C:     state_next = S_DEN;
      S_DEN:       state_next = S_DIV_GO;
      S_DIV_GO:    state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (d_done) state_next = S_UPD;
      S_UPD:       state_next = S_ROT_GO;
      S_SQ:        state_next = S_ROOT_INIT;
      S_ROOT_INIT: state_next = S_ROOT;
      S_ROOT:      if (sq_bit[0]) state_next = S_MUL_Y;
      S_MUL_Y:     state_next = S_VEC_GO;
      S_VEC_GO:    state_next = S_VEC_WAIT;
      S_VEC_WAIT:  if (c_done) state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          m          <= m_clamped;
          e          <= m_clamped;
          n          <= '0;
          conv       <= 1'b0;
          final_pass <= 1'b0;
        end
      end
      S_ROT_WAIT: begin
        if (c_done) begin
          s_val <= c_out_y;
          c_val <= c_out_x;
        end
      end
      S_MUL_C: f30 <= diff_q30 - RESID_W'(prod_sh);
      S_DEN:   d30 <= (den_full < 1) ? DEN_W'(1) : DEN_W'(den_full);
      S_UPD: begin
        e <= e_next;
        n <= n_inc;
        if (hit) begin
          conv       <= 1'b1;
          final_pass <= 1'b1;
        end else if (n_inc == NW'(MAX_ITERATIONS)) begin
          final_pass <= 1'b1;
        end
      end
      S_ROOT_INIT: begin
        sq_v   <= ROOT_TOP - ROOT_W'(prod[31:0]);
        sq_r   <= '0;
        sq_bit <= ROOT_TOP;
      end
      S_ROOT: begin
        if (sq_v >= sq_t) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      S_VEC_WAIT: begin
        if (c_done) begin
          if (nu_full > CORDIC_W'(PI_ANGLE)) begin
            nu <= PI_ANGLE;
          end else if (nu_full < -CORDIC_W'(PI_ANGLE)) begin
            nu <= -PI_ANGLE;
          end else begin
            nu <= ANGLE_W'(nu_full);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          eccentric_angle <= e;
          true_angle      <= nu;
          converged       <= conv;
          steps_used      <= (32'(n) > 32'd31) ? 5'd31 : 5'(n);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/kas_cordic.sv =====
`default_nettype none

module kas_cordic
  import kas_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cordic_ctrl_t               ctrl,
  input  logic signed [CORDIC_W-1:0] in_x,
  input  logic signed [CORDIC_W-1:0] in_y,
  input  logic signed [CORDIC_W-1:0] in_z,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] out_x,
  output logic signed [CORDIC_W-1:0] out_y,
  output logic signed [CORDIC_W-1:0] out_z
);

  localparam logic [CORDIC_IDX_W-1:0] LAST = CORDIC_IDX_W'(CORDIC_STEPS - 1);

  logic                       busy;
  logic                       mode;
  logic                       negate;
  logic                       zero;
  logic [CORDIC_IDX_W-1:0]    idx;
  logic signed [CORDIC_W-1:0] x, y, z;
  logic signed [CORDIC_W-1:0] dx, dy, ang;
  logic                       up;

  assign dx  = y >>> idx;
  assign dy  = x >>> idx;
  assign ang = atan_q30(idx);
  assign up  = mode ? !(y > 0) : (z >= 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && idx == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode <= ctrl.vectoring;
      idx  <= '0;
      if (!ctrl.vectoring) begin
        x    <= GAIN_INV;
        y    <= '0;
        zero <= 1'b0;
        if (in_z > HALF_PI_TRIG) begin
          z      <= in_z - PI_TRIG;
          negate <= 1'b1;
        end else if (in_z < -HALF_PI_TRIG) begin
          z      <= in_z + PI_TRIG;
          negate <= 1'b1;
        end else begin
          z      <= in_z;
          negate <= 1'b0;
        end
      end else begin
        negate <= 1'b0;
        zero   <= (in_x == 0) && (in_y == 0);
        if (in_x < 0) begin
          z <= (in_y >= 0) ? PI_TRIG : -PI_TRIG;
          x <= -in_x;
          y <= -in_y;
        end else begin
          z <= '0;
          x <= in_x;
          y <= in_y;
        end
      end
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (up) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end
    end
  end

  assign out_x = negate ? -x : x;
  assign out_y = negate ? -y : y;
  assign out_z = zero ? '0 : z;

endmodule

`default_nettype wire

// ===== rtl/kas_divider.sv =====
`default_nettype none

module kas_divider
  import kas_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [STEP_W-1:0] quot
);

  localparam int CNT_W = $clog2(QUOT_BITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_BITS - 1);

  logic                 busy;
  logic                 ovf;
  logic [CNT_W-1:0]     cnt;
  logic [DEN_W:0]       rem;
  logic [QUOT_BITS-1:0] low;
  logic [QUOT_BITS-1:0] q;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem[DEN_W-1:0], low[QUOT_BITS-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf <= DEN_W'(num[NUM_W-1:QUOT_BITS]) >= den;
      rem <= (DEN_W + 1)'(num[NUM_W-1:QUOT_BITS]);
      low <= num[QUOT_BITS-1:0];
      q   <= '0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      low <= low << 1;
      q   <= {q[QUOT_BITS-2:0], fits};
      rem <= fits ? trial - {1'b0, den} : trial;
    end
  end

  assign quot = (ovf || q > QUOT_BITS'(STEP_LIMIT)) ? STEP_LIMIT : q[STEP_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/kas_checker.sv =====
`default_nettype none

module kas_checker
  import kas_pkg::*;
#(
  parameter int MAX_ITERATIONS  = DEF_MAX_ITERATIONS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      mean_valid,
  input logic                      mean_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic signed [ANGLE_W-1:0] eccentric_angle,
  input logic signed [ANGLE_W-1:0] true_angle,
  input logic                      converged,
  input logic [4:0]                steps_used
);

  localparam logic [63:0] PI_ANGLE_U =
    (PI_Q62 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  localparam logic signed [ANGLE_W-1:0] PI_ANGLE = ANGLE_W'(PI_ANGLE_U);
  localparam logic [4:0] STEP_CAP = (MAX_ITERATIONS > 31) ? 5'd31 : 5'(MAX_ITERATIONS);

  // one word in flight: the input side closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    mean_valid && !mean_stall |=> mean_stall)
    else $error("word accepted while another was in flight");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(eccentric_angle)
      && $stable(true_angle) && $stable(converged) && $stable(steps_used))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && converged |-> steps_used != 5'd0 && steps_used <= STEP_CAP)
    else $error("converged word with bad step count");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !converged |-> steps_used == STEP_CAP)
    else $error("unconverged word below the step cap");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> eccentric_angle <= PI_ANGLE && eccentric_angle >= -PI_ANGLE
      && true_angle <= PI_ANGLE && true_angle >= -PI_ANGLE)
    else $error("result angle outside [-pi, pi]");

endmodule

bind kepler_anomaly_solver kas_checker #(
  .MAX_ITERATIONS  (MAX_ITERATIONS),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_kas_checker (
  .clk             (clk),
  .rst             (rst),
  .mean_valid      (mean_valid),
  .mean_stall      (mean_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .eccentric_angle (eccentric_angle),
  .true_angle      (true_angle),
  .converged       (converged),
  .steps_used      (steps_used)
);

`default_nettype wire
